@@ rtl/core/bpc_pkg.sv @@
// Package for the button pulse classifier: window sizes, button indices,
// command and event codes, and the types shared by the core modules.
// No dependencies.
package bpc_pkg;

  localparam int unsigned SAMPLES_PER_WINDOW = 6;
  localparam int unsigned SHORT_SPAN         = 3;
  localparam int unsigned NUM_BUTTONS        = 5;

  localparam int unsigned SPAN_EFF =
    (SHORT_SPAN > SAMPLES_PER_WINDOW) ? SAMPLES_PER_WINDOW : SHORT_SPAN;
  localparam int unsigned CNT_W  = $clog2(SAMPLES_PER_WINDOW + 1);
  localparam int unsigned EVT_W  = 4;
  localparam int unsigned BTN_IDX_W = $clog2(NUM_BUTTONS);

  typedef logic [NUM_BUTTONS-1:0]        levels_t;
  typedef logic [SAMPLES_PER_WINDOW-1:0] hist_t;
  typedef hist_t [NUM_BUTTONS-1:0]       hist_arr_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [EVT_W-1:0]              event_t;

  localparam hist_t FULL_MASK  = '1;
  localparam hist_t SHORT_MASK =
    hist_t'(((64'd1 << SPAN_EFF) - 64'd1) << (SAMPLES_PER_WINDOW - SPAN_EFF));

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  localparam logic [BTN_IDX_W-1:0] BTN_DOWN   = BTN_IDX_W'(0);
  localparam logic [BTN_IDX_W-1:0] BTN_LEFT   = BTN_IDX_W'(1);
  localparam logic [BTN_IDX_W-1:0] BTN_CENTER = BTN_IDX_W'(2);
  localparam logic [BTN_IDX_W-1:0] BTN_UP     = BTN_IDX_W'(3);
  localparam logic [BTN_IDX_W-1:0] BTN_RIGHT  = BTN_IDX_W'(4);

  localparam logic [BTN_IDX_W-1:0] PRIO_ORDER [NUM_BUTTONS] =
    '{BTN_CENTER, BTN_LEFT, BTN_DOWN, BTN_UP, BTN_RIGHT};

  localparam event_t EVT_MAX = event_t'(2 * NUM_BUTTONS - 1);

  // End-of-window snapshot from the history stage
  typedef struct packed {
    logic      done;
    hist_arr_t hist;
  } win_t;

  // Classification result
  typedef struct packed {
    logic   hit;
    event_t code;
  } cls_t;

endpackage

@@ rtl/core/bpc_if.sv @@
// Valid/ready channel interfaces for the button pulse classifier.
// Depends on bpc_pkg.
interface bpc_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  bpc_pkg::levels_t  levels;

  modport source (output valid, output cmd, output levels, input ready);
  modport sink   (input valid, input cmd, input levels, output ready);
endinterface

interface bpc_out_if;
  logic             valid;
  logic             ready;
  bpc_pkg::event_t  event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

@@ rtl/core/bpc_history.sv @@
// Per-button sample histories, tick counter and window arm flag.
// Reports the final histories on the closing tick. Depends on bpc_pkg.
module bpc_history (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              cmd,
  input  bpc_pkg::levels_t  levels,
  output bpc_pkg::win_t     win
);
  import bpc_pkg::*;

  hist_arr_t hist_r, hist_nxt;
  cnt_t      cnt_r, cnt_nxt;
  logic      armed_r, armed_nxt;
  hist_arr_t shifted;
  logic      last_tick;

  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      shifted[b] = {hist_r[b][SAMPLES_PER_WINDOW-2:0], levels[b]};
    end
  end

  assign last_tick = (cnt_r == cnt_t'(SAMPLES_PER_WINDOW - 1));

  always_comb begin
    hist_nxt  = hist_r;
    cnt_nxt   = cnt_r;
    armed_nxt = armed_r;
    win.done  = 1'b0;
    win.hist  = shifted;
    if (fire) begin
      if (cmd == CMD_EDGE) begin
        hist_nxt  = '0;
        cnt_nxt   = '0;
        armed_nxt = 1'b1;
      end else if (armed_r) begin
        if (last_tick) begin
          hist_nxt  = '0;
          cnt_nxt   = '0;
          armed_nxt = 1'b0;
          win.done  = 1'b1;
        end else begin
          hist_nxt = shifted;
          cnt_nxt  = cnt_r + cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      cnt_r   <= '0;
      armed_r <= 1'b0;
    end else begin
      hist_r  <= hist_nxt;
      cnt_r   <= cnt_nxt;
      armed_r <= armed_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < cnt_t'(SAMPLES_PER_WINDOW))
    else $error("tick count past window");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (cnt_r == '0 && hist_r == '0))
    else $error("disarmed window holds samples");

  a_edge_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd == CMD_EDGE) |=> (armed_r && cnt_r == '0 && hist_r == '0))
    else $error("edge did not restart window");

endmodule

@@ rtl/core/bpc_classify.sv @@
// Long/short press classifier with fixed button priority.
// Depends on bpc_pkg.
module bpc_classify (
  input  bpc_pkg::hist_arr_t hist,
  output bpc_pkg::cls_t      cls
);
  import bpc_pkg::*;

  hist_t h;

  always_comb begin
    cls.hit  = 1'b0;
    cls.code = '0;
    h        = '0;
    for (int r = NUM_BUTTONS - 1; r >= 0; r--) begin
      h = hist[PRIO_ORDER[r]];
      if (h == FULL_MASK) begin
        cls.hit  = 1'b1;
        cls.code = event_t'(2 * r);
      end else if ((h & SHORT_MASK) != '0) begin
        cls.hit  = 1'b1;
        cls.code = event_t'(2 * r + 1);
      end
    end
  end

endmodule

@@ rtl/core/button_pulse_classifier_unit.sv @@
// Top level of the button pulse classifier: history stage, classifier and
// result register. Depends on bpc_pkg, bpc_if, bpc_history, bpc_classify.
//
// Usage:
//   in_bus carries one item per transfer: cmd (edge or tick) and the five
//   button levels. An edge clears all histories and arms a window; each
//   tick while armed shifts in one sample per button. The tick that fills
//   the window classifies and may produce one event_code on out_bus.
//   An event appears on out_bus the cycle after the closing tick's transfer.
//   Throughput: one item per cycle unless out_bus stalls; the history update
//   and the priority select fit between the state registers and the result
//   register. A stalled receiver holds the event in the result register;
//   in_bus stays ready while out_bus is empty or is being drained in the
//   same cycle. Reset (rst_n low, synchronous) clears histories, the tick
//   count, the armed flag and the result valid; no clearing sweep is needed.
module button_pulse_classifier_unit (
  input  logic         clk,
  input  logic         rst_n,
  bpc_in_if.sink       in_bus,
  bpc_out_if.source    out_bus
);
  import bpc_pkg::*;

  logic   in_fire;
  win_t   win;
  cls_t   cls;
  logic   out_valid_r, out_valid_nxt;
  event_t out_event_r, out_event_nxt;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  bpc_history u_history (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (in_fire),
    .cmd    (in_bus.cmd),
    .levels (in_bus.levels),
    .win    (win)
  );

  bpc_classify u_classify (
    .hist (win.hist),
    .cls  (cls)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_event_nxt = out_event_r;
    if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && win.done && cls.hit) begin
      out_valid_nxt = 1'b1;
      out_event_nxt = cls.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_event_r <= out_event_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.event_code = out_event_r;

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_event_r <= EVT_MAX)
    else $error("event code out of range");

  a_event_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && in_bus.cmd == CMD_TICK && win.done))
    else $error("event without closing tick");

endmodule

@@ sim/tb.sv @@
// Self-checking bench for button_pulse_classifier_unit: feeds edge and tick
// items on in_bus, predicts each press event and checks event_code on out_bus.
// Depends on bpc_pkg, bpc_if and the RTL of the block.
`timescale 1ns / 100ps

module tb;
  import bpc_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_ITEMS = 100;
  localparam int unsigned ITEM_GOAL  = 900;

  typedef struct packed {
    cmd_t    cmd;
    levels_t levels;
  } button_item_t;

  logic clk;
  logic rst_n;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  button_pulse_classifier_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  button_item_t button_items [$];
  event_t       predicted_events [$];

  hist_arr_t   press_hist;
  cnt_t        ticks_seen;
  bit          window_open;

  int unsigned items_queued;
  int unsigned in_count;
  int unsigned out_count;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  bit          hold_done;
  logic        tail_phase;
  int unsigned idle_run;
  int unsigned fail_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void classify_press(input cmd_t cmd, input levels_t lv,
                                         output bit hit, output event_t code);
    hist_t h;
    hit  = 1'b0;
    code = '0;
    if (cmd == CMD_EDGE) begin
      press_hist  = '0;
      ticks_seen  = '0;
      window_open = 1'b1;
      return;
    end
    if (!window_open) return;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      press_hist[b] = {press_hist[b][SAMPLES_PER_WINDOW-2:0], lv[b]};
    end
    ticks_seen = ticks_seen + 1'b1;
    if (ticks_seen < SAMPLES_PER_WINDOW) return;
    window_open = 1'b0;
    ticks_seen  = '0;
    for (int r = 0; r < NUM_BUTTONS; r++) begin
      h = press_hist[PRIO_ORDER[r]];
      if (!hit && h == FULL_MASK) begin
        hit  = 1'b1;
        code = event_t'(2 * r);
      end else if (!hit && (h & SHORT_MASK) != '0) begin
        hit  = 1'b1;
        code = event_t'(2 * r + 1);
      end
    end
    press_hist = '0;
  endfunction

  task automatic queue_item(input cmd_t cmd, input levels_t lv);
    button_items.push_back('{cmd: cmd, levels: lv});
  endtask

  // Build one window: per-button press shapes, oldest sample first.
  task automatic queue_window(input int unsigned n_ticks);
    hist_t   shape [NUM_BUTTONS];
    levels_t lv;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      case ($urandom_range(0, 8))
        0, 1, 2: shape[b] = '0;
        3: shape[b] = FULL_MASK;
        4: shape[b] = hist_t'($urandom)
                      | (hist_t'(1) << (SAMPLES_PER_WINDOW - 1 - $urandom_range(0, SPAN_EFF - 1)));
        5: shape[b] = hist_t'($urandom) & ~SHORT_MASK;
        6: shape[b] = FULL_MASK & ~(hist_t'(1) << $urandom_range(0, SAMPLES_PER_WINDOW - 1));
        default: shape[b] = hist_t'($urandom);
      endcase
    end
    queue_item(CMD_EDGE, levels_t'($urandom));
    items_queued++;
    for (int t = 0; t < n_ticks; t++) begin
      for (int b = 0; b < NUM_BUTTONS; b++) lv[b] = shape[b][SAMPLES_PER_WINDOW - 1 - t];
      queue_item(CMD_TICK, lv);
      items_queued++;
    end
  endtask

  // Driver: hold the item until transfer, predict on transfer.
  always @(posedge clk) begin : drive
    bit           hit;
    event_t       code;
    button_item_t it;
    int unsigned  idle_pct;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tail_phase  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        classify_press(cmd_t'(in_ch.cmd), in_ch.levels, hit, code);
        if (hit) predicted_events.push_back(code);
        in_count++;
      end
      case ((in_count / 64) % 3)
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (button_items.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 99) < idle_pct) begin
          src_gap = $urandom_range(0, 11);
          in_ch.valid <= 1'b0;
        end else begin
          it = button_items.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.cmd    <= it.cmd;
          in_ch.levels <= it.levels;
        end
      end
      tail_phase <= (button_items.size() < TAIL_ITEMS);
    end
  end

  // Monitor: check each event transfer and pace ready.
  always @(posedge clk) begin : monitor
    event_t      want;
    int unsigned stall_pct;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_count++;
        if (predicted_events.size() == 0) begin
          $error("event_code: no event expected, actual %0d", out_ch.event_code);
          fail_count++;
        end else begin
          want = predicted_events.pop_front();
          if (out_ch.event_code !== want) begin
            $error("event_code: expected %0d, actual %0d", want, out_ch.event_code);
            fail_count++;
          end
        end
      end
      case ((out_count / 16) % 3)
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && out_count >= 20) begin
        hold_done = 1'b1;
        hold_left = 150;
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
        sink_gap = $urandom_range(0, 11);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  initial begin
    do @(posedge clk); while (idle_run < IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : main
    int unsigned sel;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_EDGE;
    in_ch.levels = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    press_hist   = '0;
    ticks_seen   = '0;
    window_open  = 1'b0;

    // tick with no window open
    queue_item(CMD_TICK, '1);
    // all held for the whole window: center long
    queue_item(CMD_EDGE, '0);
    repeat (SAMPLES_PER_WINDOW) queue_item(CMD_TICK, '1);
    // restart mid-window, then right pressed only on the first sample
    queue_item(CMD_EDGE, '1);
    repeat (2) queue_item(CMD_TICK, '1);
    queue_item(CMD_EDGE, levels_t'($urandom));
    queue_item(CMD_TICK, levels_t'(1) << BTN_RIGHT);
    repeat (SAMPLES_PER_WINDOW - 1) queue_item(CMD_TICK, '0);
    // window closes with nothing pressed
    queue_item(CMD_EDGE, '0);
    repeat (SAMPLES_PER_WINDOW) queue_item(CMD_TICK, '0);

    while (items_queued < ITEM_GOAL) begin
      sel = $urandom_range(0, 99);
      if (sel < 82) begin
        queue_window(SAMPLES_PER_WINDOW);
      end else if (sel < 92) begin
        queue_window($urandom_range(0, SAMPLES_PER_WINDOW - 1));
      end else if (sel < 97) begin
        repeat ($urandom_range(1, 3)) queue_item(CMD_TICK, levels_t'($urandom));
      end else begin
        queue_item(CMD_EDGE, levels_t'($urandom));
        items_queued++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (button_items.size() != 0 || in_ch.valid || predicted_events.size() != 0);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
